>>> hw/rtl/sfwd_pkg.sv
package sfwd_pkg;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned PORT_W   = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned COUNT_W  = 24;
  localparam int unsigned WINDOW_W = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOD_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SECONDS  = 1'd1;

  localparam logic [COUNT_W-1:0]  THRESHOLD_RESET = 24'd100;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET    = 8'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC
  } state_t;

  // one row of the flow memory
  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [PORT_W-1:0]  port;
    logic [TIME_W-1:0]  win_begin;
    logic [COUNT_W-1:0] syns;
  } flow_entry_t;

  typedef struct packed {
    logic        en;
    flow_entry_t entry;
  } flow_write_t;

endpackage

>>> hw/rtl/sfwd_flow_mem.sv
module sfwd_flow_mem #(
  parameter int unsigned FLOW_SLOTS = 64,
  parameter int unsigned IDX_W      = 6
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [IDX_W-1:0]         rd_addr,
  output sfwd_pkg::flow_entry_t    rd_data,
  input  sfwd_pkg::flow_write_t    wr,
  input  logic [IDX_W-1:0]         wr_addr
);

  sfwd_pkg::flow_entry_t mem [FLOW_SLOTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/syn_flood_window_detector.sv
// channel   direction  handshake            payload
// -------   ---------  -------------------  --------------------------------------------
// in        input      in_valid / in_stall  dest_addr dest_port source_addr syn_bit
//                                           ack_bit now_seconds
// out       output     out_valid/out_stall  alert alert_source alert_dest alert_port
//                                           alert_count untracked
// cfg       input      cfg_write            cfg_index cfg_data
//
// scan: an item reads the memory one entry per cycle, at most fill entries, where fill is the
//   number of flows held; then the calc step checks the window
// reset: synchronous; clears the fill count, the sequencer, out_valid and the configuration
//   registers to their defaults; no clearing pass, since flows occupy a prefix of the memory
// stalls: an item is taken only while the sequencer is idle; a finished result waits in
//   the output register, and the calc step holds while that register is full and stalled
module syn_flood_window_detector #(
  parameter int unsigned FLOW_SLOTS = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  // input item channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [sfwd_pkg::ADDR_W-1:0]        dest_addr,
  input  logic [sfwd_pkg::PORT_W-1:0]        dest_port,
  input  logic [sfwd_pkg::ADDR_W-1:0]        source_addr,
  input  logic                               syn_bit,
  input  logic                               ack_bit,
  input  logic [sfwd_pkg::TIME_W-1:0]        now_seconds,
  // result item channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               alert,
  output logic [sfwd_pkg::ADDR_W-1:0]        alert_source,
  output logic [sfwd_pkg::ADDR_W-1:0]        alert_dest,
  output logic [sfwd_pkg::PORT_W-1:0]        alert_port,
  output logic [sfwd_pkg::COUNT_W-1:0]       alert_count,
  output logic                               untracked,
  // configuration write port
  input  logic                               cfg_write,
  input  logic [sfwd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sfwd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned IDX_W = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(FLOW_SLOTS + 1);
  localparam logic [CNT_W-1:0] FILL_FULL = CNT_W'(FLOW_SLOTS);

  // configuration registers
  logic [sfwd_pkg::COUNT_W-1:0]  flood_threshold;
  logic [sfwd_pkg::WINDOW_W-1:0] window_seconds;

  always_ff @(posedge clk) begin
    if (rst) begin
      flood_threshold <= sfwd_pkg::THRESHOLD_RESET;
      window_seconds  <= sfwd_pkg::WINDOW_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sfwd_pkg::CFG_FLOOD_THRESHOLD: flood_threshold <= cfg_data;
        sfwd_pkg::CFG_WINDOW_SECONDS:  window_seconds  <= cfg_data[sfwd_pkg::WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and working registers
  sfwd_pkg::state_t state, state_next;
  logic [CNT_W-1:0]  fill, fill_next;        // flows held, always slots 0..fill-1
  logic [CNT_W-1:0]  scan_idx, scan_idx_next;
  logic              pend, pend_next;        // a read is in flight
  logic [IDX_W-1:0]  pend_idx, pend_idx_next;
  logic [IDX_W-1:0]  hit_idx, hit_idx_next;
  logic              is_new, is_new_next;
  logic              is_full, is_full_next;
  logic [sfwd_pkg::TIME_W-1:0]  start, start_next;
  logic [sfwd_pkg::COUNT_W-1:0] count, count_next;

  // latched item
  logic [sfwd_pkg::ADDR_W-1:0] key_addr;
  logic [sfwd_pkg::PORT_W-1:0] key_port;
  logic [sfwd_pkg::ADDR_W-1:0] src_addr;
  logic                        pure_syn;
  logic [sfwd_pkg::TIME_W-1:0] now;

  // flow memory
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  sfwd_pkg::flow_entry_t rd_data;
  sfwd_pkg::flow_write_t wr;

  sfwd_flow_mem #(
    .FLOW_SLOTS (FLOW_SLOTS),
    .IDX_W      (IDX_W)
  ) u_flow_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr),
    .wr_addr (hit_idx)
  );

  logic in_take;
  assign in_take = in_valid && !in_stall;
  assign in_stall = (state != sfwd_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (in_take) begin
      key_addr <= dest_addr;
      key_port <= dest_port;
      src_addr <= source_addr;
      pure_syn <= syn_bit && !ack_bit;
      now      <= now_seconds;
    end
  end

  // window check: the shared subtract-and-compare of the calc step
  logic [sfwd_pkg::TIME_W-1:0]  elapsed;
  logic                         close_win;
  logic                         fire;
  logic [sfwd_pkg::COUNT_W-1:0] count_base;
  logic [sfwd_pkg::COUNT_W-1:0] count_new;
  logic [sfwd_pkg::TIME_W-1:0]  start_new;

  always_comb begin
    elapsed    = now - start;
    close_win  = elapsed >= {{(sfwd_pkg::TIME_W-sfwd_pkg::WINDOW_W){1'b0}}, window_seconds};
    fire       = close_win && (count >= flood_threshold) && !is_full;
    count_base = close_win ? '0 : count;
    count_new  = (pure_syn && count_base != sfwd_pkg::COUNT_MAX)
                 ? count_base + 1'b1 : count_base;
    start_new  = close_win ? now : start;
  end

  logic scan_more;
  logic match;
  logic out_free;
  logic finish;

  assign scan_more = scan_idx < fill;
  assign match     = pend && rd_data.addr == key_addr && rd_data.port == key_port;
  assign out_free  = !(out_valid && out_stall);

  always_comb begin
    state_next    = state;
    fill_next     = fill;
    scan_idx_next = scan_idx;
    pend_next     = 1'b0;
    pend_idx_next = pend_idx;
    hit_idx_next  = hit_idx;
    is_new_next   = is_new;
    is_full_next  = is_full;
    start_next    = start;
    count_next    = count;
    rd_en         = 1'b0;
    rd_addr       = scan_idx[IDX_W-1:0];
    wr.en         = 1'b0;
    wr.entry      = '{addr: key_addr, port: key_port,
                      win_begin: start_new, syns: count_new};
    finish        = 1'b0;

    unique case (state)
      sfwd_pkg::ST_IDLE: begin
        if (in_take) begin
          scan_idx_next = '0;
          state_next    = sfwd_pkg::ST_SCAN;
        end
      end
      sfwd_pkg::ST_SCAN: begin
        priority if (match) begin
          // first matching flow, its data is on the read port now
          hit_idx_next = pend_idx;
          start_next   = rd_data.win_begin;
          count_next   = rd_data.syns;
          is_new_next  = 1'b0;
          is_full_next = 1'b0;
          state_next   = sfwd_pkg::ST_CALC;
        end else if (!scan_more) begin
          // unknown flow: lowest free slot is the fill position
          is_full_next = (fill == FILL_FULL);
          is_new_next  = (fill != FILL_FULL);
          hit_idx_next = fill[IDX_W-1:0];
          start_next   = now;
          count_next   = '0;
          state_next   = sfwd_pkg::ST_CALC;
        end else begin
          rd_en         = 1'b1;
          pend_next     = 1'b1;
          pend_idx_next = scan_idx[IDX_W-1:0];
          scan_idx_next = scan_idx + 1'b1;
        end
      end
      sfwd_pkg::ST_CALC: begin
        if (out_free) begin
          finish     = 1'b1;
          wr.en      = !is_full;
          fill_next  = is_new ? fill + 1'b1 : fill;
          state_next = sfwd_pkg::ST_IDLE;
        end
      end
      default: state_next = sfwd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfwd_pkg::ST_IDLE;
      fill  <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx <= scan_idx_next;
    pend_idx <= pend_idx_next;
    hit_idx  <= hit_idx_next;
    is_new   <= is_new_next;
    is_full  <= is_full_next;
    start    <= start_next;
    count    <= count_next;
  end

  // output register, holds a result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      alert        <= fire;
      alert_source <= fire ? src_addr : '0;
      alert_dest   <= fire ? key_addr : '0;
      alert_port   <= fire ? key_port : '0;
      alert_count  <= fire ? count : '0;
      untracked    <= is_full;
    end
  end

  // fill count never runs past the memory depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_FULL)
    else $error("flow fill count beyond table depth");

  // a full-table result never carries an alert
  a_untracked_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && untracked) |-> !alert)
    else $error("alert on untracked item");

  // a flow is added only when the calc step completes
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && fill != $past(fill)) |->
      ($past(state) == sfwd_pkg::ST_CALC && fill == $past(fill) + 1'b1))
    else $error("fill count changed outside calc step");

endmodule
